>>> design/cubic_bezier_flattener_top_assert.svh
// assertion macros shared by the cubic bezier flattener modules
`ifndef CUBIC_BEZIER_FLATTENER_TOP_ASSERT_SVH
`define CUBIC_BEZIER_FLATTENER_TOP_ASSERT_SVH

// property that holds in every cycle out of reset
`define CBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cbf_pkg.sv
// shared types and constants of the cubic bezier flattener
package cbf_pkg;

  // sample index width and register defaults
  localparam int IDX_BITS = 6;
  localparam logic [IDX_BITS-1:0] SUBDIV_RESET = 6'd15;

  // default coordinate and fraction widths
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 24;

  // segment queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  // queue status seen by the sequencer and the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // sample control travelling down the evaluation pipeline
  typedef struct packed {
    logic                vld;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } smp_ctl_t;

endpackage

>>> design/cbf_front.sv
// front end: takes segment words and holds them in a short queue
`include "cubic_bezier_flattener_top_assert.svh"

module cbf_front import cbf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [7:0][COORD_BITS-1:0] pts_in,
  input  logic                       pop,
  output logic [7:0][COORD_BITS-1:0] pts_out,
  output q_stat_t                    stat
);

  logic [7:0][COORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]       wptr_r, wptr_nxt;
  logic [QPTR_BITS-1:0]       rptr_r, rptr_nxt;
  logic [QCNT_BITS-1:0]       count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= pts_in;
    end
  end

  assign pts_out    = mem[rptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));

  `CBF_ASSERT(a_cnt_bound, count_r <= QCNT_BITS'(QUEUE_DEPTH), "queue count beyond depth")
  `CBF_ASSERT(a_pop_nonempty, pop |-> (count_r != '0), "pop from empty queue")
  `CBF_ASSERT_NEXT(a_cnt_up, push && !pop, count_r == $past(count_r) + 1'b1, "push lost")

endmodule

>>> design/cbf_seq.sv
// back end sequencer: steps the curve parameter over one segment per queue word
`include "cubic_bezier_flattener_top_assert.svh"

module cbf_seq import cbf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [IDX_BITS-1:0]        cfg_wr_data,
  input  q_stat_t                    q_stat,
  input  logic [7:0][COORD_BITS-1:0] q_pts,
  output logic                       q_pop,
  output smp_ctl_t                   iss_ctl,
  output logic [FRAC_BITS:0]         iss_t,
  output logic [7:0][COORD_BITS-1:0] iss_pts
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int NUM_N = 1 << IDX_BITS;
  localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

  // per divisor step: quotient and remainder of 2^F over n
  logic [TW-1:0]       q_tab [NUM_N];
  logic [IDX_BITS-1:0] r_tab [NUM_N];

  assign q_tab[0] = '0;
  assign r_tab[0] = '0;
  for (genvar n = 1; n < NUM_N; n++) begin : g_tab
    localparam longint unsigned QV = (64'd1 << FRAC_BITS) / n;
    localparam longint unsigned RV = (64'd1 << FRAC_BITS) % n;
    assign q_tab[n] = TW'(QV);
    assign r_tab[n] = IDX_BITS'(RV);
  end

  // subdivision register and its step constants
  logic [IDX_BITS-1:0] n_r;
  logic [TW-1:0]       step_q_r;
  logic [IDX_BITS-1:0] step_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= SUBDIV_RESET;
      step_q_r <= q_tab[SUBDIV_RESET];
      step_r_r <= r_tab[SUBDIV_RESET];
    end else if (cfg_wr_en) begin
      n_r      <= cfg_wr_data;
      step_q_r <= q_tab[cfg_wr_data];
      step_r_r <= r_tab[cfg_wr_data];
    end
  end

  // segment state, latched when a segment starts
  logic [IDX_BITS-1:0]        seg_n_r, seg_n_nxt;
  logic [TW-1:0]              seg_q_r, seg_q_nxt;
  logic [IDX_BITS-1:0]        seg_rm_r, seg_rm_nxt;
  logic                       iss_vld_r, iss_vld_nxt;
  logic                       iss_last_r, iss_last_nxt;
  logic [IDX_BITS-1:0]        iss_idx_r, iss_idx_nxt;
  logic [TW-1:0]              t_r, t_nxt;
  logic [IDX_BITS-1:0]        rem_r, rem_nxt;
  logic [7:0][COORD_BITS-1:0] pts_r, pts_nxt;
  logic                       done;
  logic [IDX_BITS:0]          rem_sum;
  logic                       carry;

  // next sample: load a new segment, advance t by 1/n, or drop valid when done
  always_comb begin
    done    = !iss_vld_r || iss_last_r;
    q_pop   = done && !q_stat.empty;
    rem_sum = {1'b0, rem_r} + {1'b0, seg_rm_r};
    carry   = (rem_sum >= {1'b0, seg_n_r});

    seg_n_nxt    = seg_n_r;
    seg_q_nxt    = seg_q_r;
    seg_rm_nxt   = seg_rm_r;
    iss_vld_nxt  = iss_vld_r;
    iss_last_nxt = iss_last_r;
    iss_idx_nxt  = iss_idx_r;
    t_nxt        = t_r;
    rem_nxt      = rem_r;
    pts_nxt      = pts_r;

    if (q_pop) begin
      seg_n_nxt    = n_r;
      seg_q_nxt    = step_q_r;
      seg_rm_nxt   = step_r_r;
      iss_vld_nxt  = 1'b1;
      iss_last_nxt = (n_r == '0);
      iss_idx_nxt  = '0;
      t_nxt        = '0;
      rem_nxt      = n_r >> 1;
      pts_nxt      = q_pts;
    end else if (done) begin
      iss_vld_nxt = 1'b0;
    end else begin
      iss_idx_nxt  = iss_idx_r + 1'b1;
      iss_last_nxt = (iss_idx_nxt == seg_n_r);
      t_nxt        = t_r + seg_q_r + TW'(carry);
      rem_nxt      = carry ? IDX_BITS'(rem_sum - {1'b0, seg_n_r}) : IDX_BITS'(rem_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r <= 1'b0;
    end else begin
      iss_vld_r <= iss_vld_nxt;
    end
    seg_n_r    <= seg_n_nxt;
    seg_q_r    <= seg_q_nxt;
    seg_rm_r   <= seg_rm_nxt;
    iss_last_r <= iss_last_nxt;
    iss_idx_r  <= iss_idx_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    pts_r      <= pts_nxt;
  end

  assign iss_ctl.vld  = iss_vld_r;
  assign iss_ctl.last = iss_last_r;
  assign iss_ctl.idx  = iss_idx_r;
  assign iss_t        = t_r;
  assign iss_pts      = pts_r;

  `CBF_ASSERT_NEXT(a_idx_step, iss_vld_r && !iss_last_r, iss_vld_r && iss_idx_r == $past(iss_idx_r) + 1'b1, "sample index skipped")
  `CBF_ASSERT(a_last_idx, iss_vld_r && iss_last_r |-> iss_idx_r == seg_n_r, "last flag off the final step")
  `CBF_ASSERT(a_last_t, iss_vld_r && iss_last_r && seg_n_r != '0 |-> t_r == ONE_T, "t not one at the end")

endmodule

>>> design/cbf_eval.sv
// back end evaluator: bernstein weights, weighted sums and integer conversion
module cbf_eval import cbf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smp_ctl_t                   iss_ctl,
  input  logic [FRAC_BITS:0]         iss_t,
  input  logic [7:0][COORD_BITS-1:0] iss_pts,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      out_point_x,
  output logic [COORD_BITS-1:0]      out_point_y,
  output logic [IDX_BITS-1:0]        out_sample_index,
  output logic                       out_last_point
);

  localparam int TW = FRAC_BITS + 1;
  localparam int WW = FRAC_BITS + 4;
  localparam int PW = WW + COORD_BITS;
  localparam int SW = PW + 2;
  localparam int QW = SW - FRAC_BITS;
  localparam logic [2*TW-1:0] HALF = (2*TW)'(1) << (FRAC_BITS - 1);
  localparam logic signed [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] BIAS = (SW'(1) << FRAC_BITS) - SW'(1);
  localparam logic signed [QW-1:0] MAXC = (QW'(1) << (COORD_BITS - 1)) - QW'(1);
  localparam logic signed [QW-1:0] MINC = -MAXC - QW'(1);

  function automatic logic signed [WW-1:0] times3(input logic signed [WW-1:0] v);
    times3 = v + (v <<< 1);
  endfunction

  // truncate toward zero and saturate to the coordinate range
  function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] adj;
    logic signed [QW-1:0] q;
    adj = s[SW-1] ? s + BIAS : s;
    q   = adj[SW-1:FRAC_BITS];
    if (q > MAXC) begin
      to_coord = MAXC[COORD_BITS-1:0];
    end else if (q < MINC) begin
      to_coord = MINC[COORD_BITS-1:0];
    end else begin
      to_coord = q[COORD_BITS-1:0];
    end
  endfunction

  // stage 1: t squared
  smp_ctl_t                   ctl1_r;
  logic [TW-1:0]              t_1_r, t2_1_r;
  logic [7:0][COORD_BITS-1:0] pts1_r;
  logic [2*TW-1:0]            sq;

  assign sq = (2*TW)'(iss_t) * (2*TW)'(iss_t) + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= iss_ctl;
    end
    t_1_r  <= iss_t;
    t2_1_r <= sq[FRAC_BITS +: TW];
    pts1_r <= iss_pts;
  end

  // stage 2: t cubed
  smp_ctl_t                   ctl2_r;
  logic [TW-1:0]              t_2_r, t2_2_r, t3_2_r;
  logic [7:0][COORD_BITS-1:0] pts2_r;
  logic [2*TW-1:0]            cu;

  assign cu = (2*TW)'(t2_1_r) * (2*TW)'(t_1_r) + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
    t_2_r  <= t_1_r;
    t2_2_r <= t2_1_r;
    t3_2_r <= cu[FRAC_BITS +: TW];
    pts2_r <= pts1_r;
  end

  // stage 3: bernstein weights
  smp_ctl_t                   ctl3_r;
  logic signed [WW-1:0]       w_r [4];
  logic [7:0][COORD_BITS-1:0] pts3_r;
  logic signed [WW-1:0]       ts, t2s, t3s;

  assign ts  = $signed(WW'(t_2_r));
  assign t2s = $signed(WW'(t2_2_r));
  assign t3s = $signed(WW'(t3_2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl2_r;
    end
    w_r[0] <= ONE_W - t3s + times3(t2s - ts);
    w_r[1] <= times3(t3s - (t2s <<< 1) + ts);
    w_r[2] <= times3(t2s - t3s);
    w_r[3] <= t3s;
    pts3_r <= pts2_r;
  end

  // stage 4: one product per weight and coordinate
  smp_ctl_t             ctl4_r;
  logic signed [PW-1:0] px_r [4];
  logic signed [PW-1:0] py_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else begin
      ctl4_r <= ctl3_r;
    end
    for (int k = 0; k < 4; k++) begin
      px_r[k] <= PW'(w_r[k]) * PW'($signed(pts3_r[2*k]));
      py_r[k] <= PW'(w_r[k]) * PW'($signed(pts3_r[2*k+1]));
    end
  end

  // stage 5: weighted sums
  smp_ctl_t             ctl5_r;
  logic signed [SW-1:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else begin
      ctl5_r <= ctl4_r;
    end
    sx_r <= SW'(px_r[0]) + SW'(px_r[1]) + SW'(px_r[2]) + SW'(px_r[3]);
    sy_r <= SW'(py_r[0]) + SW'(py_r[1]) + SW'(py_r[2]) + SW'(py_r[3]);
  end

  // stage 6: output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [IDX_BITS-1:0]   out_idx_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl5_r.vld;
    end
    out_x_r    <= to_coord(sx_r);
    out_y_r    <= to_coord(sy_r);
    out_idx_r  <= ctl5_r.idx;
    out_last_r <= ctl5_r.last;
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_sample_index = out_idx_r;
  assign out_last_point   = out_last_r;

endmodule

>>> design/cubic_bezier_flattener_top.sv
// top level of the cubic bezier flattener
//
// One word on the in_ ports is one cubic segment (start, two control points,
// end). It is taken at a clock edge with start high and busy low. busy is
// high only while the two-entry segment queue is full.
// For n = subdivisions the block returns n+1 points at t = j/n, j = 0..n, one
// per cycle, each shown for one cycle with out_valid high; the final point
// carries out_last_point. With n = 0 a single point (the start point) comes
// back, marked last. When the block is idle, the first point of an accepted
// segment appears once it has passed the queue, the sequencer registers and
// the evaluator pipeline stages. The sequencer issues one parameter step per
// cycle; a new segment may be given every cycle while the queue has room,
// and its points follow the previous segment's without a gap.
// cfg_wr_en/cfg_wr_data write subdivisions; a segment uses the value seen
// when it leaves the queue. Reset (rst_n low, synchronous) empties the queue
// and pipeline and sets subdivisions to 15. The receiver cannot stall.
module cubic_bezier_flattener_top import cbf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_ctrl_a_x,
  input  logic [COORD_BITS-1:0] in_ctrl_a_y,
  input  logic [COORD_BITS-1:0] in_ctrl_b_x,
  input  logic [COORD_BITS-1:0] in_ctrl_b_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic                  cfg_wr_en,
  input  logic [IDX_BITS-1:0]   cfg_wr_data,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic [IDX_BITS-1:0]   out_sample_index,
  output logic                  out_last_point
);

  logic [7:0][COORD_BITS-1:0] in_pts;
  logic [7:0][COORD_BITS-1:0] q_pts;
  logic [7:0][COORD_BITS-1:0] iss_pts;
  logic                       push;
  logic                       q_pop;
  q_stat_t                    q_stat;
  smp_ctl_t                   iss_ctl;
  logic [FRAC_BITS:0]         iss_t;

  // segment word: x and y of each control point, start point lowest
  assign in_pts = {in_end_y, in_end_x, in_ctrl_b_y, in_ctrl_b_x,
                   in_ctrl_a_y, in_ctrl_a_x, in_start_y, in_start_x};
  assign busy   = q_stat.full;
  assign push   = start && !q_stat.full;

  cbf_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pts_in  (in_pts),
    .pop     (q_pop),
    .pts_out (q_pts),
    .stat    (q_stat)
  );

  cbf_seq #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_pts       (q_pts),
    .q_pop       (q_pop),
    .iss_ctl     (iss_ctl),
    .iss_t       (iss_t),
    .iss_pts     (iss_pts)
  );

  cbf_eval #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .iss_ctl          (iss_ctl),
    .iss_t            (iss_t),
    .iss_pts          (iss_pts),
    .out_valid        (out_valid),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_sample_index (out_sample_index),
    .out_last_point   (out_last_point)
  );

endmodule

>>> test/cubic_bezier_flattener_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the cubic bezier flattener top level
module cubic_bezier_flattener_top_tb;
  import cbf_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_ROWS = 17;
  localparam int RANDOM_PHASES = 6;
  localparam int SEGS_PER_PHASE = 25;
  localparam int MAX_PRINTS = 40;

  // one segment word: start point, two control points, end point
  typedef struct packed {
    logic [CW-1:0] sx, sy, ax, ay, bx, by, ex, ey;
  } segment_t;

  // directed row: subdivisions to run with, and an optional constant point
  typedef struct packed {
    logic [IDX_BITS-1:0] subdiv;
    logic                typed;
    logic [CW-1:0]       tx, ty;
    segment_t            seg;
  } seg_row_t;

  typedef struct {
    logic [CW-1:0]       x, y;
    logic [IDX_BITS-1:0] idx;
    logic                last;
  } curve_point_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CW-1:0]       in_start_x, in_start_y, in_ctrl_a_x, in_ctrl_a_y;
  logic [CW-1:0]       in_ctrl_b_x, in_ctrl_b_y, in_end_x, in_end_y;
  logic                cfg_wr_en;
  logic [IDX_BITS-1:0] cfg_wr_data;
  logic                out_valid;
  logic [CW-1:0]       out_point_x, out_point_y;
  logic [IDX_BITS-1:0] out_sample_index;
  logic                out_last_point;

  curve_point_t        pending_points[$];
  logic [IDX_BITS-1:0] subdiv_now;
  int                  cycle_count = 0;
  int                  mismatches = 0;
  int                  points_checked = 0;
  int                  segments_sent = 0;
  int                  settings_used = 0;

  // directed segments: extremes, saturation, truncation, zero/one/max steps
  seg_row_t stimulus_rows [NUM_ROWS] = '{
    '{subdiv: 6'd15, typed: 1'b1, tx: 24'd0, ty: 24'd0,
      seg: '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0}},
    '{subdiv: 6'd15, typed: 1'b1, tx: CMAX, ty: CMAX,
      seg: '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
    '{subdiv: 6'd15, typed: 1'b1, tx: CMIN, ty: CMIN,
      seg: '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
    '{subdiv: 6'd15, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
    '{subdiv: 6'd15, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
    '{subdiv: 6'd15, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}},
    '{subdiv: 6'd15, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{24'd0, 24'd0, 24'd100, 24'd300, 24'd400, -24'sd300, 24'd500, 24'd0}},
    '{subdiv: 6'd15, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{-24'sd1, -24'sd7, -24'sd3, 24'd5, 24'd2, -24'sd9, -24'sd5, 24'd1}},
    '{subdiv: 6'd0, typed: 1'b1, tx: 24'd1234, ty: -24'sd4321,
      seg: '{24'd1234, -24'sd4321, 24'd99, 24'd98, -24'sd97, 24'd96, 24'd95, -24'sd94}},
    '{subdiv: 6'd0, typed: 1'b1, tx: CMIN, ty: CMAX,
      seg: '{CMIN, CMAX, 24'd0, 24'd0, CMAX, CMIN, 24'd17, -24'sd17}},
    '{subdiv: 6'd1, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{-24'sd1000, 24'd2000, 24'd3000, -24'sd4000, 24'd5000, 24'd6000,
             -24'sd7000, 24'd8000}},
    '{subdiv: 6'd1, typed: 1'b1, tx: CMAX, ty: CMAX,
      seg: '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
    '{subdiv: 6'd63, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{24'd0, 24'd0, -24'sd200000, 24'd800000, 24'd600000, -24'sd800000,
             24'd400000, 24'd0}},
    '{subdiv: 6'd63, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
    '{subdiv: 6'd63, typed: 1'b1, tx: 24'h555555, ty: 24'hAAAAAA,
      seg: '{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
             24'h555555, 24'hAAAAAA}},
    '{subdiv: 6'd2, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{24'd10, -24'sd10, -24'sd3000000, 24'd3000000, 24'd3000000,
             -24'sd3000000, -24'sd10, 24'd10}},
    '{subdiv: 6'd3, typed: 1'b0, tx: 24'd0, ty: 24'd0,
      seg: '{-24'sd8, 24'd8, 24'd1, -24'sd1, 24'd7, -24'sd7, 24'd0, 24'd3}}
  };

  cubic_bezier_flattener_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_ctrl_a_x      (in_ctrl_a_x),
    .in_ctrl_a_y      (in_ctrl_a_y),
    .in_ctrl_b_x      (in_ctrl_b_x),
    .in_ctrl_b_y      (in_ctrl_b_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_sample_index (out_sample_index),
    .out_last_point   (out_last_point)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // weighted sum of one axis, truncated toward zero and clamped to the coord range
  function automatic logic [CW-1:0] blend_coord(input longint w0, w1, w2, w3,
                                                input logic [CW-1:0] p0, p1, p2, p3);
    longint acc, mag, q, hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    acc = w0 * longint'($signed(p0)) + w1 * longint'($signed(p1))
        + w2 * longint'($signed(p2)) + w3 * longint'($signed(p3));
    mag = (acc < 0) ? -acc : acc;
    q = mag >> FW;
    if (acc < 0) q = -q;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[CW-1:0];
  endfunction

  // expected points of one segment at t = j/n, queued in order of j
  function automatic void predict_segment(input segment_t s, input logic [IDX_BITS-1:0] n,
                                          input logic typed,
                                          input logic [CW-1:0] tx, ty);
    longint one, half, nn, t, t2, t3, w0, w1, w2, w3;
    int top;
    curve_point_t pt;
    one = longint'(1) << FW;
    half = one >> 1;
    nn = longint'(n);
    top = int'(n);
    for (int j = 0; j <= top; j++) begin
      t = (nn == 0) ? 0 : ((longint'(j) << FW) + (nn >> 1)) / nn;
      t2 = (t * t + half) >> FW;
      t3 = (t2 * t + half) >> FW;
      w0 = one - t3 + 3 * (t2 - t);
      w1 = 3 * (t3 - 2 * t2 + t);
      w2 = 3 * (t2 - t3);
      w3 = t3;
      pt.x = blend_coord(w0, w1, w2, w3, s.sx, s.ax, s.bx, s.ex);
      pt.y = blend_coord(w0, w1, w2, w3, s.sy, s.ay, s.by, s.ey);
      // typed rows give their constant point everywhere (one point repeated, or the start point at n = 0)
      if (typed) begin
        pt.x = tx;
        pt.y = ty;
      end
      pt.idx = j[IDX_BITS-1:0];
      pt.last = (j == top);
      pending_points.push_back(pt);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // put one segment word on the bus and hold it until taken
  task automatic send_segment(input segment_t s);
    in_start_x  <= s.sx;
    in_start_y  <= s.sy;
    in_ctrl_a_x <= s.ax;
    in_ctrl_a_y <= s.ay;
    in_ctrl_b_x <= s.bx;
    in_ctrl_b_y <= s.by;
    in_end_x    <= s.ex;
    in_end_y    <= s.ey;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    segments_sent++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  // drain all points, let the pipeline settle, then write subdivisions
  task automatic set_subdivisions(input logic [IDX_BITS-1:0] n);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    subdiv_now = n;
    settings_used++;
  endtask

  // full-range values half the time, else extremes and small values near zero
  function automatic logic [CW-1:0] random_coord();
    case ($urandom_range(0, 9)) inside
      0:       return CMAX;
      1:       return CMIN;
      [2:4]:   return CW'($urandom_range(0, 4000)) - CW'(2000);
      default: return CW'($urandom);
    endcase
  endfunction

  // compare each point word with the oldest expected point
  always @(posedge clk) begin
    curve_point_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point x=%0d y=%0d idx=%0d",
                        $signed(out_point_x), $signed(out_point_y), out_sample_index));
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (out_point_x !== want.x)
          report_mismatch($sformatf("idx %0d point_x got %0d want %0d", want.idx,
                          $signed(out_point_x), $signed(want.x)));
        if (out_point_y !== want.y)
          report_mismatch($sformatf("idx %0d point_y got %0d want %0d", want.idx,
                          $signed(out_point_y), $signed(want.y)));
        if (out_sample_index !== want.idx)
          report_mismatch($sformatf("sample_index got %0d want %0d",
                          out_sample_index, want.idx));
        if (out_last_point !== want.last)
          report_mismatch($sformatf("idx %0d last_point got %0b want %0b", want.idx,
                          out_last_point, want.last));
      end
    end
  end

  // timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d points outstanding",
             cycle_count, pending_points.size());
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int idle_pct;
    segment_t s;
    logic [IDX_BITS-1:0] phase_n;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_start_x  <= '0;
    in_start_y  <= '0;
    in_ctrl_a_x <= '0;
    in_ctrl_a_y <= '0;
    in_ctrl_b_x <= '0;
    in_ctrl_b_y <= '0;
    in_end_x    <= '0;
    in_end_y    <= '0;
    subdiv_now = SUBDIV_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, starting on the reset value of subdivisions
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (stimulus_rows[r].subdiv != subdiv_now) set_subdivisions(stimulus_rows[r].subdiv);
      if ($urandom_range(0, 3) == 0) idle_burst();
      send_segment(stimulus_rows[r].seg);
      predict_segment(stimulus_rows[r].seg, subdiv_now, stimulus_rows[r].typed,
                      stimulus_rows[r].tx, stimulus_rows[r].ty);
    end

    // random segments, one subdivisions setting per phase, no idling in the last
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       phase_n = IDX_BITS'(1);
        1:       phase_n = IDX_BITS'(63);
        2:       phase_n = IDX_BITS'(0);
        3:       phase_n = IDX_BITS'($urandom_range(2, 62));
        4:       phase_n = IDX_BITS'($urandom_range(2, 8));
        default: phase_n = IDX_BITS'($urandom_range(1, 20));
      endcase
      set_subdivisions(phase_n);
      idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 60);
      for (int k = 0; k < SEGS_PER_PHASE; k++) begin
        s = '{random_coord(), random_coord(), random_coord(), random_coord(),
              random_coord(), random_coord(), random_coord(), random_coord()};
        if ($urandom_range(1, 100) <= idle_pct) idle_burst();
        send_segment(s);
        predict_segment(s, subdiv_now, 1'b0, '0, '0);
      end
    end

    // drain and let any stray point show up
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d segments, checked %0d curve points", segments_sent, points_checked);
    $display("subdivisions written %0d times (0, 1 and 63 included), %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
